>>> sv/gda_pkg.sv
// shared types, constants and calendar tables for the date adder
package gda_pkg;

  // result status codes
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_BAD_OFFSET = 2'd1;
  localparam logic [1:0] STAT_BAD_DATE   = 2'd2;

  // field widths
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int OFS_W   = 9;
  localparam int DOY_W   = 10;
  localparam int STAT_W  = 2;
  localparam int Q100_W  = 8;

  // packed word widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  // year / 100 by reciprocal: floor(y * 5243 / 2^19) is exact below 16384
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  localparam logic [DOY_W-1:0]   YLEN_LEAP = 10'd366;
  localparam logic [DOY_W-1:0]   YLEN_REG  = 10'd365;
  localparam logic [MONTH_W-1:0] LAST_IDX  = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_LAST  = 5'd31;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_LEAP,
    S_CHECK,
    S_WRAP,
    S_SEARCH,
    S_DONE
  } gda_state_t;

  // first day of year of each month, index 0 is january
  function automatic logic [8:0] month_start(input logic leap, input logic [MONTH_W-1:0] idx);
    logic [8:0] s;
    case (idx)
      4'd0:    s = 9'd1;
      4'd1:    s = 9'd32;
      4'd2:    s = leap ? 9'd61  : 9'd60;
      4'd3:    s = leap ? 9'd92  : 9'd91;
      4'd4:    s = leap ? 9'd122 : 9'd121;
      4'd5:    s = leap ? 9'd153 : 9'd152;
      4'd6:    s = leap ? 9'd183 : 9'd182;
      4'd7:    s = leap ? 9'd214 : 9'd213;
      4'd8:    s = leap ? 9'd245 : 9'd244;
      4'd9:    s = leap ? 9'd275 : 9'd274;
      4'd10:   s = leap ? 9'd306 : 9'd305;
      4'd11:   s = leap ? 9'd336 : 9'd335;
      default: s = 9'd1;
    endcase
    return s;
  endfunction

  // length of a month given as 1..12, zero for codes that are no month
  function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                 input logic [MONTH_W-1:0] month);
    logic [DAY_W-1:0] n;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
      4'd2:                                        n = leap ? 5'd29 : 5'd28;
      default:                                     n = 5'd0;
    endcase
    return n;
  endfunction

  // quotient of year by 100
  function automatic logic [Q100_W-1:0] div100(input logic [YEAR_W-1:0] y);
    logic [YEAR_W+12:0] p;
    p = y * DIV100_MUL;
    return p[YEAR_W+12 -: Q100_W];
  endfunction

endpackage

>>> sv/gda_leap.sv
// leap year unit: registered divide by 100, then the century rule
module gda_leap (
  input  logic                          clk,
  input  logic [gda_pkg::YEAR_W-1:0]    year,
  output logic                          leap
);

  logic [gda_pkg::Q100_W-1:0] q_r;
  logic [gda_pkg::YEAR_W-1:0] cent;

  // quotient is registered, valid in the cycle after the year settles
  always_ff @(posedge clk) begin
    q_r <= gda_pkg::div100(year);
  end

  // divisible by 4, and a century year only when its quotient is divisible by 4
  assign cent = gda_pkg::YEAR_W'(q_r) * 14'd100;
  assign leap = (year[1:0] == 2'd0) && ((year != cent) || (q_r[1:0] == 2'd0));

endmodule

>>> sv/gregorian_date_add_days.sv
// date adder top level: sequencer around a shared leap unit and month search
//
//  channel  dir  tdata (low bit up)                         tuser
//  in_      in   day 5, month 4, year 14, offset 9          -
//  out_     out  day 5, month 4, year 14, zero pad 1        status 2
//
// an item runs from acceptance through divide, leap and the check: a rejected word
// ends after the check, a wrap into the next year repeats divide and leap, and the
// month search walks one month boundary per cycle.
// in_tready is high only while the sequencer is idle; a finished result waits in
// the output register while the next word is taken. reset clears state and valid.
module gregorian_date_add_days #(
  parameter int MAX_OFFSET = 300
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [gda_pkg::IN_DATA_W-1:0]     in_tdata,   // day, month, year, offset_days
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [gda_pkg::OUT_DATA_W-1:0]    out_tdata,  // day_out, month_out, year_out, pad
  output logic [gda_pkg::STAT_W-1:0]        out_tuser   // status
);

  gda_pkg::gda_state_t state_r, state_nxt;

  logic [gda_pkg::DAY_W-1:0]   day_r, day_nxt;
  logic [gda_pkg::MONTH_W-1:0] month_r, month_nxt;
  logic [gda_pkg::YEAR_W-1:0]  year_r, year_nxt;
  logic [gda_pkg::OFS_W-1:0]   offset_r, offset_nxt;
  logic [gda_pkg::DOY_W-1:0]   doy_r, doy_nxt;
  logic                        leap_r, leap_nxt;
  logic                        wrap_r, wrap_nxt;
  logic [gda_pkg::MONTH_W-1:0] m_r, m_nxt;
  logic [gda_pkg::DAY_W-1:0]   res_day_r, res_day_nxt;
  logic [gda_pkg::MONTH_W-1:0] res_month_r, res_month_nxt;
  logic [gda_pkg::YEAR_W-1:0]  res_year_r, res_year_nxt;
  logic [gda_pkg::STAT_W-1:0]  res_stat_r, res_stat_nxt;
  logic                        out_tvalid_r, out_tvalid_nxt;
  logic [gda_pkg::OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [gda_pkg::STAT_W-1:0]  out_tuser_r, out_tuser_nxt;

  logic                        leap_w;
  logic [gda_pkg::STAT_W-1:0]  chk_stat;
  logic [gda_pkg::DOY_W-1:0]   ylen;
  logic                        over;
  logic                        adv;
  logic                        load_out;

  // shared leap unit follows the working year
  gda_leap u_leap (
    .clk  (clk),
    .year (year_r),
    .leap (leap_w)
  );

  // input checks, offset first
  always_comb begin
    if (offset_r > gda_pkg::OFS_W'(MAX_OFFSET)) begin
      chk_stat = gda_pkg::STAT_BAD_OFFSET;
    end else if (month_r == 4'd0 || month_r > gda_pkg::MONTH_DEC) begin
      chk_stat = gda_pkg::STAT_BAD_DATE;
    end else if (day_r == 5'd0 || day_r > gda_pkg::month_len(leap_r, month_r)) begin
      chk_stat = gda_pkg::STAT_BAD_DATE;
    end else begin
      chk_stat = gda_pkg::STAT_OK;
    end
  end

  // shared compares for wrap and month search
  assign ylen     = leap_r ? gda_pkg::YLEN_LEAP : gda_pkg::YLEN_REG;
  assign over     = doy_r > ylen;
  assign adv      = (m_r < gda_pkg::LAST_IDX) &&
                    (doy_r >= gda_pkg::DOY_W'(gda_pkg::month_start(leap_r, m_r + 4'd1)));
  assign load_out = (state_r == gda_pkg::S_DONE) && (!out_tvalid_r || out_tready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gda_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = gda_pkg::S_DIV;
      end
      gda_pkg::S_DIV:  state_nxt = gda_pkg::S_LEAP;
      gda_pkg::S_LEAP: state_nxt = wrap_r ? gda_pkg::S_WRAP : gda_pkg::S_CHECK;
      gda_pkg::S_CHECK: begin
        state_nxt = (chk_stat == gda_pkg::STAT_OK) ? gda_pkg::S_WRAP : gda_pkg::S_DONE;
      end
      gda_pkg::S_WRAP: begin
        if (over && !wrap_r) state_nxt = gda_pkg::S_DIV;
        else if (over)       state_nxt = gda_pkg::S_DONE;
        else                 state_nxt = gda_pkg::S_SEARCH;
      end
      gda_pkg::S_SEARCH: begin
        if (!adv) state_nxt = gda_pkg::S_DONE;
      end
      gda_pkg::S_DONE: begin
        if (load_out) state_nxt = gda_pkg::S_IDLE;
      end
      default: state_nxt = gda_pkg::S_IDLE;
    endcase
  end

  // datapath and handshake outputs
  always_comb begin
    in_tready      = (state_r == gda_pkg::S_IDLE);
    day_nxt        = day_r;
    month_nxt      = month_r;
    year_nxt       = year_r;
    offset_nxt     = offset_r;
    doy_nxt        = doy_r;
    leap_nxt       = leap_r;
    wrap_nxt       = wrap_r;
    m_nxt          = m_r;
    res_day_nxt    = res_day_r;
    res_month_nxt  = res_month_r;
    res_year_nxt   = res_year_r;
    res_stat_nxt   = res_stat_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    case (state_r)
      gda_pkg::S_IDLE: begin
        day_nxt    = in_tdata[4:0];
        month_nxt  = in_tdata[8:5];
        year_nxt   = in_tdata[22:9];
        offset_nxt = in_tdata[31:23];
        wrap_nxt   = 1'b0;
      end
      gda_pkg::S_LEAP: begin
        leap_nxt = leap_w;
      end
      gda_pkg::S_CHECK: begin
        // day of year of the sum, at most two years long
        doy_nxt = gda_pkg::DOY_W'(gda_pkg::month_start(leap_r, month_r - 4'd1))
                + gda_pkg::DOY_W'(day_r) + gda_pkg::DOY_W'(offset_r) - 10'd1;
        res_day_nxt   = '0;
        res_month_nxt = '0;
        res_year_nxt  = '0;
        res_stat_nxt  = chk_stat;
      end
      gda_pkg::S_WRAP: begin
        if (over && !wrap_r) begin
          doy_nxt  = doy_r - ylen;
          year_nxt = year_r + 14'd1;
          wrap_nxt = 1'b1;
        end else if (over) begin
          // beyond the following year: clamp to its last day
          res_day_nxt   = gda_pkg::DAY_LAST;
          res_month_nxt = gda_pkg::MONTH_DEC;
          res_year_nxt  = year_r;
          res_stat_nxt  = gda_pkg::STAT_OK;
        end else begin
          m_nxt = 4'd0;
        end
      end
      gda_pkg::S_SEARCH: begin
        if (adv) begin
          m_nxt = m_r + 4'd1;
        end else begin
          res_day_nxt   = gda_pkg::DAY_W'(doy_r
                        - gda_pkg::DOY_W'(gda_pkg::month_start(leap_r, m_r)) + 10'd1);
          res_month_nxt = m_r + 4'd1;
          res_year_nxt  = year_r;
          res_stat_nxt  = gda_pkg::STAT_OK;
        end
      end
      gda_pkg::S_DONE: begin
        if (load_out) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {1'b0, res_year_r, res_month_r, res_day_r};
          out_tuser_nxt  = res_stat_r;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gda_pkg::S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    day_r       <= day_nxt;
    month_r     <= month_nxt;
    year_r      <= year_nxt;
    offset_r    <= offset_nxt;
    doy_r       <= doy_nxt;
    leap_r      <= leap_nxt;
    wrap_r      <= wrap_nxt;
    m_r         <= m_nxt;
    res_day_r   <= res_day_nxt;
    res_month_r <= res_month_nxt;
    res_year_r  <= res_year_nxt;
    res_stat_r  <= res_stat_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // a new word is raised only from the result stage
  a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r) == gda_pkg::S_DONE)
    else $error("output word raised outside the result stage");

  // an error word carries an all-zero date
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tuser_r != gda_pkg::STAT_OK) |-> out_tdata_r == '0)
    else $error("error word with nonzero date");

  // a good word carries a real month and day
  a_ok_date: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tuser_r == gda_pkg::STAT_OK) |->
      (out_tdata_r[8:5] != 4'd0 && out_tdata_r[8:5] <= gda_pkg::MONTH_DEC &&
       out_tdata_r[4:0] != 5'd0))
    else $error("good word with impossible date");

  // month search never runs past december
  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gda_pkg::S_SEARCH |-> m_r <= gda_pkg::LAST_IDX)
    else $error("month search index out of range");

  // a wrapped sum always fits the following year for the allowed offsets
  a_wrap_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gda_pkg::S_WRAP && wrap_r && MAX_OFFSET <= 365) |-> !over)
    else $error("sum runs past the following year");

endmodule
